// ----- hw/rtl/spq_pkg.sv -----
// Package for the sorted priority queue: shared widths, status codes,
// the cell control word and the result word. No dependencies.
`default_nettype none

package spq_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Fixed field widths of the channels
    localparam int CMD_W     = 1;
    localparam int PAY_W     = 32;
    localparam int PRIO_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Control broadcast to every cell in the row
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [PRIO_W-1:0] prio;
    } t_cell_ctl;

    // One result word
    typedef struct packed {
        t_status                  status;
        logic        [PAY_W-1:0]  out_payload;
        logic signed [PRIO_W-1:0] out_prio;
        logic                     is_empty;
        logic        [FILL_W-1:0] fill;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_if.sv -----
// Channel interfaces of the sorted priority queue: command in, result out.
// Depends on spq_pkg for the field widths.
`default_nettype none

interface spq_in_if;
    logic                               valid;
    logic                               ready;
    logic [spq_pkg::CMD_W-1:0]          command;
    logic [spq_pkg::PAY_W-1:0]          payload;
    logic signed [spq_pkg::PRIO_W-1:0]  prio;

    modport source (output valid, command, payload, prio, input ready);
    modport sink   (input valid, command, payload, prio, output ready);
endinterface

interface spq_out_if;
    logic                               valid;
    logic                               ready;
    logic [spq_pkg::STATUS_W-1:0]       status;
    logic [spq_pkg::PAY_W-1:0]          out_payload;
    logic signed [spq_pkg::PRIO_W-1:0]  out_prio;
    logic                               is_empty;
    logic [spq_pkg::FILL_W-1:0]         fill;

    modport source (output valid, status, out_payload, out_prio, is_empty, fill,
                    input ready);
    modport sink   (input valid, status, out_payload, out_prio, is_empty, fill,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted queue row: holds a priority and a payload and
// shifts towards either neighbour. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire spq_pkg::t_cell_ctl            i_ctl,
    input  wire        [PAYLOAD_BITS-1:0]      i_new_payload,
    input  wire                                i_occupied,
    input  wire                                i_left_keep,
    input  wire signed [spq_pkg::PRIO_W-1:0]   i_left_prio,
    input  wire        [PAYLOAD_BITS-1:0]      i_left_payload,
    input  wire signed [spq_pkg::PRIO_W-1:0]   i_right_prio,
    input  wire        [PAYLOAD_BITS-1:0]      i_right_payload,
    output logic                               o_keep,
    output logic signed [spq_pkg::PRIO_W-1:0]  o_prio,
    output logic       [PAYLOAD_BITS-1:0]      o_payload
);
    import spq_pkg::*;

    logic signed [PRIO_W-1:0]  r_prio;
    logic signed [PRIO_W-1:0]  n_prio;
    logic [PAYLOAD_BITS-1:0]   r_payload;
    logic [PAYLOAD_BITS-1:0]   n_payload;

    // Held entry ranks ahead of (or level with) the incoming one
    assign o_keep    = i_occupied && ($signed(r_prio) >= $signed(i_ctl.prio));
    assign o_prio    = r_prio;
    assign o_payload = r_payload;

    // Next slot contents: hold, take the new word, or shift
    always_comb begin
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_ctl.rem) begin
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end else if (i_ctl.ins && !o_keep) begin
            if (i_left_keep) begin
                n_prio    = i_ctl.prio;
                n_payload = i_new_payload;
            end else begin
                n_prio    = i_left_prio;
                n_payload = i_left_payload;
            end
        end
    end

    // Payload store, no reset
    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_payload <= n_payload;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/spq_out_buf.sv -----
// Two-word output buffer (output register plus skid) for result words.
// Depends on spq_pkg and spq_out_if.
`default_nettype none

module spq_out_buf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire spq_pkg::t_result  i_word,
    spq_out_if.source              o_res,
    output logic                   o_out_valid,
    output logic                   o_skid_valid
);
    import spq_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;
    logic    w_drain;

    assign o_ready      = !r_skid_valid;
    assign w_take       = i_valid && o_ready;
    assign w_drain      = r_out_valid && o_res.ready;
    assign o_out_valid  = r_out_valid;
    assign o_skid_valid = r_skid_valid;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_drain) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_take) begin
            if (r_out_valid && !w_drain) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_drain) begin
            r_out_valid <= 1'b0;
        end
    end

    // Word registers
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_drain) begin
                r_out <= r_skid;
            end
        end else if (w_take) begin
            if (r_out_valid && !w_drain) begin
                r_skid <= i_word;
            end else begin
                r_out <= i_word;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.out_payload = r_out.out_payload;
    assign o_res.out_prio    = r_out.out_prio;
    assign o_res.is_empty    = r_out.is_empty;
    assign o_res.fill        = r_out.fill;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_top.sv -----
// Sorted priority queue: row of DEPTH shifting cells, entry count, output buffer.
// Depends on spq_pkg, spq_if, spq_cell, spq_out_buf.
// All cells compare and shift together; result words leave via the output buffer.
// Throughput: one command word per cycle while the output buffer has room.
// Reset: synchronous, active low; empties the queue (count to zero) and the
// output buffer. Slot contents are not cleared; no clearing pass.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int DEPTH        = spq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    spq_in_if.sink     i_cmd,
    spq_out_if.source  o_res
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     w_fire;
    logic                     w_full;
    logic                     w_empty;
    t_cell_ctl                w_ctl;
    t_result                  w_res;
    logic                     w_buf_ready;
    logic                     w_out_valid;
    logic                     w_skid_valid;
    logic [PAYLOAD_BITS-1:0]  w_new_payload;

    logic                     w_keep    [DEPTH];
    logic signed [PRIO_W-1:0] w_prio    [DEPTH];
    logic [PAYLOAD_BITS-1:0]  w_payload [DEPTH];

    assign i_cmd.ready   = w_buf_ready;
    assign w_fire        = i_cmd.valid && w_buf_ready;
    assign w_full        = (r_count == CW'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_new_payload = PAYLOAD_BITS'(i_cmd.payload);

    // Command decode into the cell broadcast
    always_comb begin
        w_ctl.ins  = w_fire && (i_cmd.command == CMD_INSERT) && !w_full;
        w_ctl.rem  = w_fire && (i_cmd.command == CMD_REMOVE) && !w_empty;
        w_ctl.prio = i_cmd.prio;
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Row of cells; cell 0 is the head
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                     w_left_keep;
        logic signed [PRIO_W-1:0] w_left_prio;
        logic [PAYLOAD_BITS-1:0]  w_left_payload;
        logic signed [PRIO_W-1:0] w_right_prio;
        logic [PAYLOAD_BITS-1:0]  w_right_payload;

        if (gi == 0) begin : g_head
            assign w_left_keep    = 1'b1;
            assign w_left_prio    = i_cmd.prio;
            assign w_left_payload = w_new_payload;
        end else begin : g_body
            assign w_left_keep    = w_keep[gi-1];
            assign w_left_prio    = w_prio[gi-1];
            assign w_left_payload = w_payload[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_right_prio    = '0;
            assign w_right_payload = '0;
        end else begin : g_mid
            assign w_right_prio    = w_prio[gi+1];
            assign w_right_payload = w_payload[gi+1];
        end

        spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctl           (w_ctl),
            .i_new_payload   (w_new_payload),
            .i_occupied      (CW'(gi) < r_count),
            .i_left_keep     (w_left_keep),
            .i_left_prio     (w_left_prio),
            .i_left_payload  (w_left_payload),
            .i_right_prio    (w_right_prio),
            .i_right_payload (w_right_payload),
            .o_keep          (w_keep[gi]),
            .o_prio          (w_prio[gi]),
            .o_payload       (w_payload[gi])
        );
    end

    // Result word
    always_comb begin
        w_res.out_payload = '0;
        w_res.out_prio    = '0;
        case (i_cmd.command)
            CMD_REMOVE: begin
                if (w_empty) begin
                    w_res.status = ST_EMPTY;
                end else begin
                    w_res.status      = ST_REMOVED;
                    w_res.out_payload = PAY_W'(w_payload[0]);
                    w_res.out_prio    = w_prio[0];
                end
            end
            default: begin
                w_res.status = w_full ? ST_FULL : ST_INSERTED;
            end
        endcase
        w_res.is_empty = (n_count == '0);
        w_res.fill     = FILL_W'(n_count);
    end

    spq_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_cmd.valid),
        .o_ready      (w_buf_ready),
        .i_word       (w_res),
        .o_res        (o_res),
        .o_out_valid  (w_out_valid),
        .o_skid_valid (w_skid_valid)
    );

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_skid_valid |-> w_out_valid)
        else $error("skid word held with empty output register");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not advance the entry count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> ($signed(w_prio[0]) >= $signed(w_prio[1])))
        else $error("head entry out of priority order");

endmodule

`default_nettype wire

// ----- tb/sorted_priority_queue_top_test.sv -----
// Testbench for sorted_priority_queue_top: directed and random insert/remove words,
// with an in-bench model of the sorted store that predicts every result word.
// Depends on spq_pkg, spq_if and the RTL of the queue.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
    import spq_pkg::*;

    localparam int SLOTS     = DEPTH_DEF;
    localparam int N_RANDOM  = 1900;
    localparam int CALM_TAIL = 300;
    localparam int N_REPORT  = 10;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [PAY_W-1:0]         payload;
        logic signed [PRIO_W-1:0] prio;
    } t_cmd_word;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  cmd_if ();
    spq_out_if res_if ();

    sorted_priority_queue_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Predicted contents of the queue, head at index 0
    logic signed [PRIO_W-1:0] pq_prio [SLOTS];
    logic        [PAY_W-1:0]  pq_payload [SLOTS];
    int                       pq_count = 0;

    t_cmd_word cmd_backlog [$];
    t_result   pending_results [$];

    int   total_words    = 0;
    int   n_cmd_accepted = 0;
    int   n_errors       = 0;
    bit   cmd_taken      = 1'b0;
    bit   calm           = 1'b0;
    int   tx_gap         = 0;
    int   rx_gap         = 0;
    int   rx_hold_left   = 0;
    int   cycle_no       = 0;

    // Apply one command word to the predicted queue and return its result word
    function automatic t_result queue_apply(logic [CMD_W-1:0] cmd,
                                            logic [PAY_W-1:0] payload,
                                            logic signed [PRIO_W-1:0] prio);
        t_result r;
        int      pos;
        r             = '0;
        if (cmd == CMD_REMOVE) begin
            if (pq_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status      = ST_REMOVED;
                r.out_payload = pq_payload[0];
                r.out_prio    = pq_prio[0];
                for (int i = 1; i < pq_count; i++) begin
                    pq_prio[i-1]    = pq_prio[i];
                    pq_payload[i-1] = pq_payload[i];
                end
                pq_count--;
            end
        end else if (pq_count >= SLOTS) begin
            r.status = ST_FULL;
        end else begin
            // new entry goes behind every entry of greater or equal priority
            pos = 0;
            while (pos < pq_count && pq_prio[pos] >= prio)
                pos++;
            for (int i = pq_count; i > pos; i--) begin
                pq_prio[i]    = pq_prio[i-1];
                pq_payload[i] = pq_payload[i-1];
            end
            pq_prio[pos]    = prio;
            pq_payload[pos] = payload;
            pq_count++;
            r.status = ST_INSERTED;
        end
        r.is_empty = (pq_count == 0);
        r.fill     = FILL_W'(pq_count);
        return r;
    endfunction

    task automatic queue_word(logic [CMD_W-1:0] cmd, logic [PAY_W-1:0] payload,
                              logic signed [PRIO_W-1:0] prio);
        t_cmd_word w;
        w.cmd     = cmd;
        w.payload = payload;
        w.prio    = prio;
        cmd_backlog.push_back(w);
    endtask

    // Priority mix: full range, a narrow band for ties, and the extremes
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return PRIO_W'($urandom_range(0, 4)) - 16'sd2;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stimulus, reset and end of run
    initial begin
        int ins_pct;
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_INSERT;
        cmd_if.payload = '0;
        cmd_if.prio    = '0;
        res_if.ready   = 1'b0;
        i_rst_n        = 1'b0;

        // directed: remove on empty, extremes, ties, fill to full, overflow
        queue_word(CMD_REMOVE, 32'hffff_ffff, 16'sh7fff);
        queue_word(CMD_INSERT, 32'h0000_0000, 16'sh0000);
        queue_word(CMD_INSERT, 32'hffff_ffff, 16'sh7fff);
        queue_word(CMD_INSERT, 32'h0000_0001, 16'sh8000);
        queue_word(CMD_INSERT, 32'h8000_0000, 16'shffff);
        queue_word(CMD_INSERT, 32'h1111_0001, 16'sh0005);
        queue_word(CMD_INSERT, 32'h1111_0002, 16'sh0005);
        queue_word(CMD_INSERT, 32'h1111_0003, 16'sh0005);
        queue_word(CMD_INSERT, 32'h2222_0001, 16'sh7fff);
        queue_word(CMD_INSERT, 32'h2222_0002, 16'sh8000);
        queue_word(CMD_INSERT, 32'h5555_5555, 16'sh5555);
        queue_word(CMD_INSERT, 32'haaaa_aaaa, 16'shaaaa);
        queue_word(CMD_INSERT, 32'h3333_0001, 16'sh0000);
        queue_word(CMD_INSERT, 32'h3333_0002, 16'sh0001);
        queue_word(CMD_INSERT, 32'h3333_0003, 16'sh7ffe);
        queue_word(CMD_INSERT, 32'h3333_0004, 16'sh8001);
        queue_word(CMD_INSERT, 32'h3333_0005, 16'sh0005);
        queue_word(CMD_INSERT, 32'hdead_beef, 16'sh7fff);
        for (int i = 0; i < 6; i++)
            queue_word(CMD_REMOVE, $urandom, PRIO_W'($urandom));

        // random: blocks with a leaning towards insert or remove, so that the
        // queue swings between empty and full
        ins_pct = 50;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: ins_pct = 25;
                    1: ins_pct = 50;
                    2: ins_pct = 75;
                    default: ins_pct = 90;
                endcase
            end
            if ($urandom_range(1, 100) <= ins_pct)
                queue_word(CMD_INSERT, $urandom, pick_prio());
            else
                queue_word(CMD_REMOVE, $urandom, PRIO_W'($urandom));
        end
        total_words = cmd_backlog.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_cmd_accepted != total_words || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_errors == 0 && pending_results.size() == 0)
            $display("sorted_priority_queue_top test passed");
        else
            $display("sorted_priority_queue_top test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("sorted_priority_queue_top test failed");
        $finish;
    end

    // Command driver: holds a word until taken, idles in short bursts
    always @(negedge i_clk) begin : cmd_driver
        t_cmd_word w;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (cmd_if.valid && !cmd_taken) begin
            // word still on offer
        end else if (tx_gap != 0) begin
            tx_gap--;
            cmd_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(0, 9);
            cmd_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
            w = cmd_backlog.pop_front();
            cmd_if.valid   <= 1'b1;
            cmd_if.command <= w.cmd;
            cmd_if.payload <= w.payload;
            cmd_if.prio    <= w.prio;
        end else begin
            cmd_if.valid <= 1'b0;
        end
    end

    // Long receiver hold-offs, so the output buffer fills and stalls the input
    always @(posedge i_clk) begin : rx_hold_ctl
        if (i_rst_n) begin
            cycle_no++;
            if (rx_hold_left != 0)
                rx_hold_left--;
            else if (cycle_no == 150 || cycle_no == 1400)
                rx_hold_left = 80;
        end
    end

    // Result receiver: ready with random stall bursts
    always @(negedge i_clk) begin : res_receiver
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            res_if.ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            res_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 9);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted command, check each accepted result
    always @(posedge i_clk) begin : word_monitor
        t_result got;
        t_result want;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                cmd_taken = 1'b1;
                pending_results.push_back(
                    queue_apply(cmd_if.command, cmd_if.payload, cmd_if.prio));
                n_cmd_accepted++;
                calm = (n_cmd_accepted >= total_words - CALM_TAIL);
            end
            if (res_if.valid && res_if.ready) begin
                got.status      = t_status'(res_if.status);
                got.out_payload = res_if.out_payload;
                got.out_prio    = res_if.out_prio;
                got.is_empty    = res_if.is_empty;
                got.fill        = res_if.fill;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= N_REPORT)
                        $display("%0t: result word with none expected: status %0d fill %0d",
                                 $time, got.status, got.fill);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.out_payload !== want.out_payload
                        || got.out_prio !== want.out_prio
                        || got.is_empty !== want.is_empty || got.fill !== want.fill) begin
                        n_errors++;
                        if (n_errors <= N_REPORT) begin
                            $display("%0t: expected st %0d pay %h prio %0d empty %0b fill %0d",
                                     $time, want.status, want.out_payload, want.out_prio,
                                     want.is_empty, want.fill);
                            $display("%0t: got      st %0d pay %h prio %0d empty %0b fill %0d",
                                     $time, got.status, got.out_payload, got.out_prio,
                                     got.is_empty, got.fill);
                        end
                    end
                end
            end
        end
    end

endmodule
